FILE: design/lsc_pkg.sv
package lsc_pkg;

   localparam int SENSOR_COUNT = 8;
   localparam int LEVEL_BITS   = 10;
   localparam int POS_BITS     = 15;
   localparam int LEVEL_FULL   = 1000;

   typedef enum logic [1:0] {
      KIND_MEASURE = 2'd0,
      KIND_CAL     = 2'd1,
      KIND_RESTART = 2'd2,
      KIND_UNUSED  = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MAP_START,
      ST_MAP_WAIT,
      ST_POS_START,
      ST_POS_WAIT,
      ST_DONE
   } state_type;

   typedef logic [LEVEL_BITS-1:0] level_type;

   // doubled weights -105..105
   function automatic logic signed [7:0] twice_weight(input logic [2:0] idx);
      logic signed [7:0] w;
      w = 8'sd30 * $signed({5'd0, idx}) - 8'sd105;
      return w;
   endfunction

endpackage

FILE: design/lsc_channel_if.sv
interface lsc_req_if #(parameter int SAMPLE_BITS = 12);
   logic                   valid;
   logic                   ready;
   logic [1:0]             kind;
   logic [SAMPLE_BITS-1:0] raw_s0, raw_s1, raw_s2, raw_s3;
   logic [SAMPLE_BITS-1:0] raw_s4, raw_s5, raw_s6, raw_s7;
   modport source (output valid, kind, raw_s0, raw_s1, raw_s2, raw_s3,
                   raw_s4, raw_s5, raw_s6, raw_s7, input ready);
   modport sink (input valid, kind, raw_s0, raw_s1, raw_s2, raw_s3,
                 raw_s4, raw_s5, raw_s6, raw_s7, output ready);
endinterface

interface lsc_rsp_if;
   logic              valid;
   logic              ready;
   logic [9:0]        cal_s0, cal_s1, cal_s2, cal_s3, cal_s4, cal_s5, cal_s6, cal_s7;
   logic signed [14:0] line_position;
   logic              no_line;
   modport source (output valid, cal_s0, cal_s1, cal_s2, cal_s3, cal_s4, cal_s5,
                   cal_s6, cal_s7, line_position, no_line, input ready);
   modport sink (input valid, cal_s0, cal_s1, cal_s2, cal_s3, cal_s4, cal_s5,
                 cal_s6, cal_s7, line_position, no_line, output ready);
endinterface

interface lsc_csr_if;
   logic valid;
   logic ready;
   logic data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

FILE: design/line_sensor_calibrate_and_locate_core.sv
// Calibrated line sensor with weighted-centroid position. A calibration,
// restart or unused frame is taken, gives no result, and leaves the input
// ready. A measure frame maps the eight sensors one at a time through a
// shared bit-serial divider. For each sensor the divider is loaded, shifts
// out NUM_BITS quotient bits and raises its done flag. NUM_BITS is the larger
// of SAMPLE_BITS+10 and 29. The same divider then divides the weighted sum
// by the total (skipped when the total is zero), and the finished item is
// then handed to the output register. The result becomes valid in the same
// cycle that the input is ready again.
// The result waits in its own output register until taken, so the next frame
// can be worked on meanwhile. A finished frame holds in its last state until
// that register is free.
module line_sensor_calibrate_and_locate_core #(
   parameter int SAMPLE_BITS = 12
) (
   input  logic  clock,
   input  logic  reset,
   lsc_req_if.sink  req,
   lsc_rsp_if.source rsp,
   lsc_csr_if.sink  csr
);
   import lsc_pkg::*;

   localparam int MAP_BITS = SAMPLE_BITS + LEVEL_BITS;
   localparam int NUM_BITS = (MAP_BITS > 29) ? MAP_BITS : 29;
   localparam int DEN_BITS = (SAMPLE_BITS > 13) ? SAMPLE_BITS : 13;

   state_type state_ff, state_in;
   logic invert_ff;
   logic [SAMPLE_BITS-1:0] samples [SENSOR_COUNT];
   logic [SAMPLE_BITS-1:0] smp_ff [SENSOR_COUNT];
   logic [SAMPLE_BITS-1:0] low [SENSOR_COUNT];
   logic [SAMPLE_BITS-1:0] high [SENSOR_COUNT];
   level_type lvl_ff [SENSOR_COUNT];
   level_type out_lvl_ff [SENSOR_COUNT];
   logic [2:0] idx_ff, idx_in;
   logic signed [19:0] num_ff;
   logic [12:0] den_ff;
   logic accept, restart, widen, start, load;
   logic [NUM_BITS-1:0] div_num, quot;
   logic [DEN_BITS-1:0] div_den;
   logic div_done;
   logic [SAMPLE_BITS-1:0] lo_s, hi_s, v;
   level_type level;
   logic [9:0] q_lvl;
   logic [19:0] mag;
   logic rsp_valid_ff;
   logic signed [POS_BITS-1:0] pos_ff;
   logic signed [POS_BITS-1:0] out_pos_ff;
   logic noline_ff;
   logic out_noline_ff;

   assign samples = '{req.raw_s0, req.raw_s1, req.raw_s2, req.raw_s3,
                      req.raw_s4, req.raw_s5, req.raw_s6, req.raw_s7};
   assign req.ready = (state_ff == ST_IDLE);
   assign accept  = req.valid && req.ready;
   assign restart = accept && (req.kind == KIND_RESTART);
   assign widen   = accept && (req.kind == KIND_CAL);
   assign csr.ready = 1'b1;
   // hand the finished item over once the output register is free
   assign load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp.ready);

   lsc_window #(.SAMPLE_BITS(SAMPLE_BITS)) u_window (
      .clock, .reset, .restart, .widen, .samples, .low, .high
   );

   assign lo_s = low[idx_ff];
   assign hi_s = high[idx_ff];
   always_comb begin
      v = smp_ff[idx_ff];
      if (v < lo_s) v = lo_s;
      if (v > hi_s) v = hi_s;
   end
   assign mag = num_ff[19] ? 20'(-num_ff) : 20'(num_ff);

   always_comb begin
      div_num = '0;
      div_den = '0;
      if (state_ff == ST_MAP_START) begin
         div_num = NUM_BITS'(v - lo_s) * NUM_BITS'(LEVEL_FULL);
         div_den = DEN_BITS'(hi_s - lo_s);
      end else begin
         div_num = NUM_BITS'({mag, 7'd0});
         div_den = DEN_BITS'(den_ff);
      end
   end
   assign start = (state_ff == ST_MAP_START) || (state_ff == ST_POS_START);

   lsc_divider #(.NUM_BITS(NUM_BITS), .DEN_BITS(DEN_BITS)) u_div (
      .clock, .reset, .start, .numer(div_num), .denom(div_den),
      .done(div_done), .quot
   );

   assign q_lvl = quot[9:0];
   always_comb begin
      if (hi_s <= lo_s) level = '0;
      else if (invert_ff) level = 10'(LEVEL_FULL) - q_lvl;
      else level = q_lvl;
   end

   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req.kind == KIND_MEASURE) begin
               state_in = ST_MAP_START;
               idx_in   = '0;
            end
         end
         ST_MAP_START: state_in = ST_MAP_WAIT;
         ST_MAP_WAIT: begin
            if (div_done) begin
               idx_in = idx_ff + 1'b1;
               state_in = (idx_ff == 3'd7) ? ST_POS_START : ST_MAP_START;
            end
         end
         ST_POS_START: state_in = (den_ff == '0) ? ST_DONE : ST_POS_WAIT;
         ST_POS_WAIT: if (div_done) state_in = ST_DONE;
         ST_DONE: if (load) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         invert_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         if (csr.valid) invert_ff <= csr.data;
         if (load) rsp_valid_ff <= 1'b1;
         else if (rsp.ready) rsp_valid_ff <= 1'b0;
      end
      if (accept) begin
         smp_ff <= samples;
         num_ff <= '0;
         den_ff <= '0;
      end
      if (state_ff == ST_MAP_WAIT && div_done) begin
         lvl_ff[idx_ff] <= level;
         num_ff <= num_ff + 20'($signed({1'b0, level})) * 20'(twice_weight(idx_ff));
         den_ff <= den_ff + 13'(level);
      end
      if (state_ff == ST_POS_START && den_ff == '0) begin
         pos_ff    <= '0;
         noline_ff <= 1'b1;
      end
      if (state_ff == ST_POS_WAIT && div_done) begin
         pos_ff    <= num_ff[19] ? POS_BITS'(-quot[POS_BITS-1:0])
                                 : POS_BITS'(quot[POS_BITS-1:0]);
         noline_ff <= 1'b0;
      end
      if (load) begin
         out_lvl_ff    <= lvl_ff;
         out_pos_ff    <= pos_ff;
         out_noline_ff <= noline_ff;
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.cal_s0 = out_lvl_ff[0];
   assign rsp.cal_s1 = out_lvl_ff[1];
   assign rsp.cal_s2 = out_lvl_ff[2];
   assign rsp.cal_s3 = out_lvl_ff[3];
   assign rsp.cal_s4 = out_lvl_ff[4];
   assign rsp.cal_s5 = out_lvl_ff[5];
   assign rsp.cal_s6 = out_lvl_ff[6];
   assign rsp.cal_s7 = out_lvl_ff[7];
   assign rsp.line_position = out_pos_ff;
   assign rsp.no_line = out_noline_ff;
endmodule

FILE: design/lsc_divider.sv
// Restoring divider, one quotient bit per cycle.
module lsc_divider #(
   parameter int NUM_BITS = 24,
   parameter int DEN_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [NUM_BITS-1:0] numer,
   input  logic [DEN_BITS-1:0] denom,
   output logic                done,
   output logic [NUM_BITS-1:0] quot
);
   localparam int CNT_BITS = $clog2(NUM_BITS + 1);

   logic [NUM_BITS-1:0] quot_ff, quot_in;
   logic [DEN_BITS-1:0] rem_ff, rem_in;
   logic [DEN_BITS-1:0] den_ff, den_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [DEN_BITS:0]   trial;
   logic [DEN_BITS:0]   diff;

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quot_ff[NUM_BITS-1]};
      diff    = trial - {1'b0, den_ff};
      if (start) begin
         quot_in = numer;
         rem_in  = '0;
         den_in  = denom;
         cnt_in  = CNT_BITS'(NUM_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[DEN_BITS]) begin
            rem_in  = diff[DEN_BITS-1:0];
            quot_in = {quot_ff[NUM_BITS-2:0], 1'b1};
         end else begin
            rem_in  = trial[DEN_BITS-1:0];
            quot_in = {quot_ff[NUM_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;
endmodule

FILE: design/lsc_window.sv
// Calibration windows, one register pair per sensor.
module lsc_window #(
   parameter int SAMPLE_BITS = 12
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   restart,
   input  logic                   widen,
   input  logic [SAMPLE_BITS-1:0] samples [8],
   output logic [SAMPLE_BITS-1:0] low [8],
   output logic [SAMPLE_BITS-1:0] high [8]
);
   import lsc_pkg::*;

   logic [SAMPLE_BITS-1:0] low_ff [SENSOR_COUNT];
   logic [SAMPLE_BITS-1:0] high_ff [SENSOR_COUNT];

   always_ff @(posedge clock) begin
      for (int i = 0; i < SENSOR_COUNT; i++) begin
         if (reset || restart) begin
            low_ff[i]  <= '1;
            high_ff[i] <= '0;
         end else if (widen) begin
            if (samples[i] < low_ff[i])  low_ff[i]  <= samples[i];
            if (samples[i] > high_ff[i]) high_ff[i] <= samples[i];
         end
      end
   end

   assign low  = low_ff;
   assign high = high_ff;
endmodule

FILE: design/lsc_checker.sv
module lsc_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic no_line,
   input logic signed [14:0] line_position
);
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && no_line |-> line_position == '0)
      else $error("no_line with nonzero position");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(line_position) && $stable(no_line))
      else $error("result changed while waiting");
endmodule

bind line_sensor_calibrate_and_locate_core lsc_checker u_lsc_checker (
   .clock, .reset,
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .no_line(rsp.no_line),
   .line_position(rsp.line_position)
);

FILE: dv/line_sensor_calibrate_and_locate_core_tb.sv
module line_sensor_calibrate_and_locate_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import lsc_pkg::*;

   typedef struct {
      kind_type   kind;
      logic [11:0] raw[8];
   } frame_type;

   typedef struct {
      logic [9:0]         level[8];
      logic signed [14:0] position;
      logic               no_line;
   } locate_type;

   class centroid_scoreboard;
      logic [11:0] win_lo[8];
      logic [11:0] win_hi[8];
      bit          invert;
      locate_type  pending[$];
      int          errors;

      function void restart();
         for (int i = 0; i < 8; i++) begin
            win_lo[i] = 12'hFFF;
            win_hi[i] = 12'h000;
         end
      endfunction

      function void note_frame(frame_type f);
         locate_type r;
         longint  num;
         longint  den;
         longint  q;
         int      c;
         int      v;
         num = 0;
         den = 0;
         case (f.kind)
            KIND_RESTART: restart();
            KIND_CAL: begin
               for (int i = 0; i < 8; i++) begin
                  if (f.raw[i] < win_lo[i]) win_lo[i] = f.raw[i];
                  if (f.raw[i] > win_hi[i]) win_hi[i] = f.raw[i];
               end
            end
            KIND_MEASURE: begin
               for (int i = 0; i < 8; i++) begin
                  if (win_hi[i] <= win_lo[i]) begin
                     c = 0;
                  end else begin
                     v = f.raw[i];
                     if (v < win_lo[i]) v = win_lo[i];
                     if (v > win_hi[i]) v = win_hi[i];
                     c = ((v - win_lo[i]) * LEVEL_FULL) / (win_hi[i] - win_lo[i]);
                     if (invert) c = LEVEL_FULL - c;
                  end
                  r.level[i] = c[9:0];
                  num += longint'(c) * (30 * i - 105);
                  den += c;
               end
               if (den == 0) begin
                  r.position = '0;
                  r.no_line = 1'b1;
               end else begin
                  q = ((num < 0 ? -num : num) * 128) / den;
                  if (num < 0) q = -q;
                  r.position = q[14:0];
                  r.no_line = 1'b0;
               end
               pending.push_back(r);
            end
            default: ;
         endcase
      endfunction

      function void check_result(locate_type got);
         locate_type exp;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result pos=%0d", $time, got.position);
            errors++;
            return;
         end
         exp = pending.pop_front();
         for (int i = 0; i < 8; i++)
            if (got.level[i] !== exp.level[i]) begin
               $display("%0t: cal_s%0d expected %0d actual %0d", $time, i,
                        exp.level[i], got.level[i]);
               errors++;
            end
         if (got.position !== exp.position) begin
            $display("%0t: line_position expected %0d actual %0d", $time,
                     exp.position, got.position);
            errors++;
         end
         if (got.no_line !== exp.no_line) begin
            $display("%0t: no_line expected %0d actual %0d", $time,
                     exp.no_line, got.no_line);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   always #1 clock = ~clock;

   lsc_req_if #(.SAMPLE_BITS(12)) req();
   lsc_rsp_if rsp();
   lsc_csr_if csr();

   line_sensor_calibrate_and_locate_core #(.SAMPLE_BITS(12)) u_top (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source), .csr(csr.sink)
   );

   centroid_scoreboard sb = new();
   int  hold_cycles = 0;
   int  quiet_cycles = 0;
   bit  done = 1'b0;

   initial begin
      req.valid = 1'b0;
      req.kind = KIND_MEASURE;
      {req.raw_s0, req.raw_s1, req.raw_s2, req.raw_s3} = '0;
      {req.raw_s4, req.raw_s5, req.raw_s6, req.raw_s7} = '0;
      csr.valid = 1'b0;
      csr.data = 1'b0;
   end

   // receiver stall pattern, with a long hold-off requested by hold_cycles
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp.ready <= 1'b0;
      end else begin
         rsp.ready <= ($urandom_range(0, 3) != 0);
      end
   end

   always @(posedge clock) begin
      locate_type got;
      if (!reset && rsp.valid && rsp.ready) begin
         got.level[0] = rsp.cal_s0; got.level[1] = rsp.cal_s1;
         got.level[2] = rsp.cal_s2; got.level[3] = rsp.cal_s3;
         got.level[4] = rsp.cal_s4; got.level[5] = rsp.cal_s5;
         got.level[6] = rsp.cal_s6; got.level[7] = rsp.cal_s7;
         got.position = rsp.line_position;
         got.no_line = rsp.no_line;
         sb.check_result(got);
      end
   end

   // watchdog on accepted handshakes
   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)
          || (csr.valid && csr.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles > 20000 && !done) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   task automatic send_frame(frame_type f, bit keep_valid);
      req.valid <= 1'b1;
      req.kind <= f.kind;
      req.raw_s0 <= f.raw[0]; req.raw_s1 <= f.raw[1];
      req.raw_s2 <= f.raw[2]; req.raw_s3 <= f.raw[3];
      req.raw_s4 <= f.raw[4]; req.raw_s5 <= f.raw[5];
      req.raw_s6 <= f.raw[6]; req.raw_s7 <= f.raw[7];
      do @(posedge clock); while (!req.ready);
      sb.note_frame(f);
      // unless keep_valid is set, drop valid between frames
      if (!keep_valid) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic write_invert(bit value);
      csr.valid <= 1'b1;
      csr.data <= value;
      do @(posedge clock); while (!csr.ready);
      sb.invert = value;
      csr.valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic frame_type make_frame(kind_type k, int lo, int hi);
      frame_type f;
      f.kind = k;
      for (int i = 0; i < 8; i++) f.raw[i] = 12'($urandom_range(lo, hi));
      return f;
   endfunction

   function automatic frame_type flat_frame(kind_type k, logic [11:0] v);
      frame_type f;
      f.kind = k;
      for (int i = 0; i < 8; i++) f.raw[i] = v;
      return f;
   endfunction

   task automatic random_frames(int count);
      frame_type f;
      int     burst;
      int     sel;
      int     lo;
      int     hi;
      burst = 0;
      for (int n = 0; n < count; n++) begin
         sel = $urandom_range(0, 99);
         if (sel < 3) begin
            f = flat_frame(KIND_RESTART, 12'($urandom));
         end else if (sel < 5) begin
            f = make_frame(KIND_UNUSED, 0, 4095);
         end else if (sel < 25) begin
            lo = $urandom_range(0, 4095);
            hi = $urandom_range(lo, 4095);
            f = make_frame(KIND_CAL, lo, hi);
         end else begin
            f = make_frame(KIND_MEASURE, 0, 4095);
            // sometimes a single sensor sees the line
            if ($urandom_range(0, 3) == 0)
               for (int i = 0; i < 8; i++)
                  if (i != n % 8) f.raw[i] = 12'($urandom_range(0, 200));
         end
         if (burst == 0) burst = $urandom_range(1, 12);
         burst--;
         send_frame(f, burst != 0);
         if (burst == 0 && $urandom_range(0, 2) != 0)
            repeat ($urandom_range(1, 40)) @(posedge clock);
      end
   endtask

   initial begin
      frame_type f;
      sb.restart();
      sb.invert = 1'b0;
      sb.errors = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty windows, a degenerate single-point window, then the full window
      send_frame(flat_frame(KIND_MEASURE, 12'd0), 0);
      send_frame(flat_frame(KIND_MEASURE, 12'hFFF), 0);
      send_frame(flat_frame(KIND_CAL, 12'd2000), 0);
      send_frame(make_frame(KIND_MEASURE, 0, 4095), 0);
      send_frame(flat_frame(KIND_CAL, 12'd0), 0);
      send_frame(flat_frame(KIND_CAL, 12'hFFF), 0);
      send_frame(flat_frame(KIND_MEASURE, 12'd0), 0);
      send_frame(flat_frame(KIND_MEASURE, 12'hFFF), 0);
      for (int s = 0; s < 8; s++) begin
         f = flat_frame(KIND_MEASURE, 12'd0);
         f.raw[s] = 12'hFFF;
         send_frame(f, 0);
      end
      send_frame(make_frame(KIND_UNUSED, 0, 4095), 0);
      send_frame(make_frame(KIND_MEASURE, 0, 4095), 0);
      drain();
      write_invert(1'b1);
      send_frame(flat_frame(KIND_MEASURE, 12'hFFF), 0);
      send_frame(flat_frame(KIND_MEASURE, 12'd0), 0);
      send_frame(flat_frame(KIND_RESTART, 12'hABC), 0);
      send_frame(make_frame(KIND_MEASURE, 0, 4095), 0);
      send_frame(make_frame(KIND_CAL, 100, 3900), 0);
      send_frame(make_frame(KIND_MEASURE, 0, 4095), 0);

      // long receiver hold-off while frames keep coming
      hold_cycles = 3000;
      random_frames(30);
      drain();
      write_invert(1'b0);
      random_frames(600);
      drain();
      write_invert(1'b1);
      random_frames(600);
      drain();
      write_invert(1'b0);
      random_frames(500);
      drain();

      done = 1'b1;
      if (sb.errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule
